// ===== design/rcpg_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpg_pkg
// Shared constants for the ratio clock pulse generator: register indexes,
// field widths and the fixed-point ratio tables.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpg_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TEMPO_W  = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned LEVELS_W = 5;
  localparam int unsigned MULT_W   = 24;
  localparam int unsigned FRAC_W   = 20;
  localparam int unsigned PERIOD_W = 20;
  localparam int unsigned TAB_IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_TEMPO  = 8'd0,
    REG_MAX_TEMPO  = 8'd1,
    REG_MIN_PERIOD = 8'd2,
    REG_PULSE      = 8'd3
  } reg_idx_e;

  // ceil(num * 2^FRAC_W / den): exact floor quotient for any 16-bit tempo
  function automatic logic [MULT_W-1:0] ratio_mult(input logic set_two,
                                                   input logic [TAB_IDX_W-1:0] idx);
    logic [MULT_W-1:0] m;
    m = '0;
    if (!set_two) begin
      case (idx)
        3'd0:    m = 24'd174763;
        3'd1:    m = 24'd131072;
        3'd2:    m = 24'd8388608;
        3'd3:    m = 24'd1258292;
        3'd4:    m = 24'd838861;
        default: m = '0;
      endcase
    end else begin
      case (idx)
        3'd0:    m = 24'd149797;
        3'd1:    m = 24'd786432;
        3'd2:    m = 24'd1747627;
        3'd3:    m = 24'd3670016;
        3'd4:    m = 24'd2359296;
        default: m = '0;
      endcase
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/rcpg_ifs.sv =====
// ----------------------------------------------------------------------------
// rcpg_ifs
// Valid/ready channels of the ratio clock pulse generator: tick input,
// level result and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcpg_in_if;
  logic                            valid;
  logic                            ready;
  logic [rcpg_pkg::TIME_W-1:0]     now_ms;
  logic [rcpg_pkg::TEMPO_W-1:0]    tempo_ms;
  logic                            swap_sets;

  modport source (output valid, output now_ms, output tempo_ms, output swap_sets,
                  input ready);
  modport sink   (input valid, input now_ms, input tempo_ms, input swap_sets,
                  output ready);
endinterface

interface rcpg_out_if;
  logic                            valid;
  logic                            ready;
  logic [rcpg_pkg::LEVELS_W-1:0]   levels_a;
  logic [rcpg_pkg::LEVELS_W-1:0]   levels_b;

  modport source (output valid, output levels_a, output levels_b, input ready);
  modport sink   (input valid, input levels_a, input levels_b, output ready);
endinterface

interface rcpg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rcpg_pkg::IDX_W-1:0]      index;
  logic [rcpg_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/ratio_clock_pulse_generator_core.sv =====
// ----------------------------------------------------------------------------
// ratio_clock_pulse_generator_core
// Two groups of pulse clocks whose periods are fixed ratios of a tempo.
// ----------------------------------------------------------------------------
// Each tick item (current time, tempo, set swap) updates two groups of
// CHANNELS pulse outputs and returns one result item with their levels.
// A single multiplier and one compare/subtract path visit the 2*CHANNELS
// outputs in turn, each in a period multiply state and then a clamp and
// toggle decision state. The tick input is not ready from acceptance until
// the result enters the output register, which waits while that register
// still holds an unaccepted result. A finished result sits in an output
// register, so the next tick can be taken while it waits. Configuration
// writes are always ready and take effect at once; write them only while idle.
`default_nettype none

module ratio_clock_pulse_generator_core #(
  parameter int unsigned CHANNELS = 5
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  rcpg_in_if.sink     in_i,
  rcpg_cfg_if.sink    cfg_i,
  rcpg_out_if.source  out_o
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned TW = rcpg_pkg::TIME_W;
  localparam int unsigned PW = rcpg_pkg::PERIOD_W;
  localparam int unsigned PROD_W = rcpg_pkg::TEMPO_W + rcpg_pkg::MULT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [CW-1:0]                ch_q;
  logic                         grp_q;

  logic [rcpg_pkg::CFG_W-1:0]   min_tempo_q, max_tempo_q, min_period_q, pulse_q;

  logic [TW-1:0]                now_q;
  logic [rcpg_pkg::TEMPO_W-1:0] tempo_q;
  logic                         swap_q;
  logic                         tval_q;

  logic [PW-1:0]                period_q;
  logic [PROD_W-1:0]            prod;

  logic [CHANNELS-1:0]          lvl_a_q, lvl_b_q;
  logic [CHANNELS-1:0][TW-1:0]  stamp_a_q, stamp_b_q;

  logic                         out_valid_q;
  logic [rcpg_pkg::LEVELS_W-1:0] out_a_q, out_b_q;

  logic                         in_acc, out_load;
  logic [PW-1:0]                per, pulse_w, w, wait_ms;
  logic                         cur_lvl, flip, last_unit;
  logic [TW-1:0]                cur_stamp, elapsed;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign last_unit   = grp_q && (ch_q == CW'(CHANNELS - 1));

  assign out_o.valid    = out_valid_q;
  assign out_o.levels_a = out_a_q;
  assign out_o.levels_b = out_b_q;

  // shared multiplier: tempo times fixed-point ratio
  assign prod = tempo_q * rcpg_pkg::ratio_mult(swap_q ^ grp_q,
                                               rcpg_pkg::TAB_IDX_W'(ch_q));

  // clamp and pulse/wait corner rules
  always_comb begin
    per = (period_q < PW'(min_period_q)) ? PW'(min_period_q) : period_q;
    pulse_w = PW'(pulse_q);
    w = pulse_w;
    if (pulse_w >= per) begin
      w = (per > PW'(1)) ? PW'(1) : '0;
    end
    if ((w == '0) && (per != '0)) begin
      w = PW'(1);
    end
    cur_lvl   = grp_q ? lvl_b_q[ch_q] : lvl_a_q[ch_q];
    cur_stamp = grp_q ? stamp_b_q[ch_q] : stamp_a_q[ch_q];
    if (cur_lvl) begin
      wait_ms = w;
    end else begin
      wait_ms = (per > w) ? (per - w) : PW'(1);
    end
    if (wait_ms == '0) begin
      wait_ms = PW'(1);
    end
    elapsed = now_q - cur_stamp;
    flip    = (elapsed >= TW'(wait_ms));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_EVAL;
      S_EVAL: state_d = last_unit ? S_DONE : S_MUL;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= '0;
      grp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        ch_q  <= '0;
        grp_q <= 1'b0;
      end else if (state_q == S_EVAL && !last_unit) begin
        grp_q <= !grp_q;
        if (grp_q) begin
          ch_q <= ch_q + CW'(1);
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_tempo_q  <= 16'd20;
      max_tempo_q  <= 16'd6000;
      min_period_q <= 16'd1;
      pulse_q      <= 16'd10;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        rcpg_pkg::REG_MIN_TEMPO:  min_tempo_q  <= cfg_i.data;
        rcpg_pkg::REG_MAX_TEMPO:  max_tempo_q  <= cfg_i.data;
        rcpg_pkg::REG_MIN_PERIOD: min_period_q <= cfg_i.data;
        rcpg_pkg::REG_PULSE:      pulse_q      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // item capture and period register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q   <= in_i.now_ms;
      tempo_q <= in_i.tempo_ms;
      swap_q  <= in_i.swap_sets;
      tval_q  <= (in_i.tempo_ms >= min_tempo_q) && (in_i.tempo_ms <= max_tempo_q);
    end
    if (state_q == S_MUL) begin
      period_q <= prod[rcpg_pkg::FRAC_W +: PW];
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_a_q   <= '0;
      lvl_b_q   <= '0;
      stamp_a_q <= '0;
      stamp_b_q <= '0;
    end else if (state_q == S_EVAL) begin
      if (!tval_q) begin
        if (grp_q) begin
          lvl_b_q[ch_q] <= 1'b0;
        end else begin
          lvl_a_q[ch_q] <= 1'b0;
        end
      end else if (flip) begin
        if (grp_q) begin
          lvl_b_q[ch_q]   <= !cur_lvl;
          stamp_b_q[ch_q] <= now_q;
        end else begin
          lvl_a_q[ch_q]   <= !cur_lvl;
          stamp_a_q[ch_q] <= now_q;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_a_q <= rcpg_pkg::LEVELS_W'(lvl_a_q);
      out_b_q <= rcpg_pkg::LEVELS_W'(lvl_b_q);
    end
  end

`ifndef SYNTHESIS
  a_invalid_tempo_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !tval_q) |-> (lvl_a_q == '0 && lvl_b_q == '0))
    else $error("levels not cleared for out-of-range tempo");

  a_stamps_only_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EVAL) |=> ($stable(stamp_a_q) && $stable(stamp_b_q)))
    else $error("toggle time changed outside evaluation");

  a_channel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_EVAL) |-> (ch_q <= CW'(CHANNELS - 1)))
    else $error("channel counter out of range");
`endif

endmodule

`default_nettype wire
